@@ hdl/rrpm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrpm_pkg
// Shared constants, types and helpers of the path rule matcher.
// ---------------------------------------------------------------------------
package rrpm_pkg;

   localparam int MAX_RULES       = 8;
   localparam int MAX_PATTERN_LEN = 32;

   localparam int FUNC_W      = 2;
   localparam int SLOT_W      = 3;
   localparam int DATA_W      = 8;
   localparam int LEN_FIELD_W = 6;

   localparam int IDX_W      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int SLOT_CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int LEN_W      = $clog2(MAX_PATTERN_LEN + 1);
   localparam int LEN_CMP_W  = (LEN_W > LEN_FIELD_W) ? LEN_W : LEN_FIELD_W;
   localparam int PIDX_W     = $clog2(MAX_PATTERN_LEN);
   localparam int POS_N      = MAX_PATTERN_LEN + 1;

   localparam logic [DATA_W-1:0] STAR_BYTE   = 8'h2A;
   localparam logic [DATA_W-1:0] DOLLAR_BYTE = 8'h24;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_CLOSE  = 2'd2,
      FUNC_PATH   = 2'd3
   } func_type;

   typedef struct packed {
      logic              valid;
      logic              start;
      func_type          func;
      logic [SLOT_W-1:0] rule_slot;
      logic [DATA_W-1:0] data_byte;
      logic              grants_access;
      logic              path_end;
   } item_type;

   typedef struct packed {
      logic             matched;
      logic             allow;
      logic [IDX_W-1:0] slot;
      logic [LEN_W-1:0] len;
   } best_type;

   localparam best_type BEST_NONE = '{matched: 1'b0, allow: 1'b1, slot: '0, len: '0};

   function automatic logic slot_hit(input logic [SLOT_W-1:0] slot,
                                     input logic [IDX_W-1:0] idx);
      return SLOT_CMP_W'(slot) == SLOT_CMP_W'(idx);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
      logic [SLOT_CMP_W-1:0] t;
      t = SLOT_CMP_W'(idx);
      return t[SLOT_W-1:0];
   endfunction

   function automatic logic [LEN_FIELD_W-1:0] len_field(input logic [LEN_W-1:0] len);
      logic [LEN_CMP_W-1:0] t;
      t = LEN_CMP_W'(len);
      return t[LEN_FIELD_W-1:0];
   endfunction

   function automatic logic item_has_result(input item_type it);
      return it.valid && (it.func == FUNC_PATH) && it.path_end;
   endfunction

endpackage

@@ hdl/rrpm_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrpm_if
// Request and response channels of the path rule matcher.
// ---------------------------------------------------------------------------
interface rrpm_req_if;
   logic                           valid;
   logic                           ready;
   logic [rrpm_pkg::FUNC_W-1:0]    func;
   logic [rrpm_pkg::SLOT_W-1:0]    rule_slot;
   logic [rrpm_pkg::DATA_W-1:0]    data_byte;
   logic                           grants_access;
   logic                           path_end;

   modport source (output valid, func, rule_slot, data_byte, grants_access, path_end,
                   input ready);
   modport sink   (input valid, func, rule_slot, data_byte, grants_access, path_end,
                   output ready);
endinterface

interface rrpm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              path_allowed;
   logic                              any_rule_matched;
   logic [rrpm_pkg::SLOT_W-1:0]       winning_slot;
   logic [rrpm_pkg::LEN_FIELD_W-1:0]  winning_length;

   modport source (output valid, path_allowed, any_rule_matched, winning_slot,
                   winning_length, input ready);
   modport sink   (input valid, path_allowed, any_rule_matched, winning_slot,
                   winning_length, output ready);
endinterface

@@ hdl/rrpm_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrpm_cell
// One rule slot: holds its pattern and automaton, applies each transaction
// as it passes and folds its verdict into the running best match.
// ---------------------------------------------------------------------------
module rrpm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rrpm_pkg::IDX_W-1:0] cell_index,
   input  logic                       advance,
   input  rrpm_pkg::item_type         item_i,
   input  rrpm_pkg::best_type         best_i,
   output rrpm_pkg::item_type         item_o,
   output rrpm_pkg::best_type         best_o
);

   function automatic logic [rrpm_pkg::POS_N-1:0] len_mask(
      input logic [rrpm_pkg::LEN_W-1:0] n);
      logic [rrpm_pkg::POS_N-1:0] m;
      m = '0;
      for (int i = 0; i < rrpm_pkg::POS_N; i++) begin
         m[i] = rrpm_pkg::LEN_W'(i) < n;
      end
      return m;
   endfunction

   function automatic logic [rrpm_pkg::POS_N-1:0] star_bits(
      input logic [rrpm_pkg::MAX_PATTERN_LEN-1:0][rrpm_pkg::DATA_W-1:0] p);
      logic [rrpm_pkg::POS_N-1:0] s;
      s = '0;
      for (int i = 0; i < rrpm_pkg::MAX_PATTERN_LEN; i++) begin
         s[i] = p[i] == rrpm_pkg::STAR_BYTE;
      end
      return s;
   endfunction

   // spread each set star position over the rest of its run of stars and the position just past it
   function automatic logic [rrpm_pkg::POS_N-1:0] closure(
      input logic [rrpm_pkg::POS_N-1:0] x,
      input logic [rrpm_pkg::POS_N-1:0] m);
      logic [rrpm_pkg::POS_N:0] s;
      s = {1'b0, x & m} + {1'b0, m};
      return x | (s[rrpm_pkg::POS_N-1:0] ^ m);
   endfunction

   logic [rrpm_pkg::MAX_PATTERN_LEN-1:0][rrpm_pkg::DATA_W-1:0] pat_ff, pat_in;
   logic [rrpm_pkg::LEN_W-1:0] len_ff, len_in;
   logic                       valid_ff, valid_in;
   logic                       ovf_ff, ovf_in;
   logic                       grants_ff, grants_in;
   logic                       anch_ff, anch_in;
   logic [rrpm_pkg::POS_N-1:0] active_ff, active_in;
   logic                       reached_ff, reached_in;
   logic [rrpm_pkg::POS_N-1:0] init_ff, init_in;
   rrpm_pkg::item_type         item_ff, item_in;
   rrpm_pkg::best_type         best_ff, best_in;

   logic                        sel, en, live, hit, take, close_ok;
   logic [rrpm_pkg::LEN_W-1:0]  n_cur, l_len, last_pos;
   logic [rrpm_pkg::POS_N-1:0]  star_cur, m_cur, base, stepv, adv_vec;
   logic                        base_reached, reached_new;

   always_comb begin
      sel      = rrpm_pkg::slot_hit(item_i.rule_slot, cell_index);
      en       = advance && item_i.valid;
      n_cur    = len_ff - rrpm_pkg::LEN_W'(anch_ff);
      star_cur = star_bits(pat_ff);
      m_cur    = star_cur & len_mask(n_cur);

      base         = item_i.start ? init_ff : active_ff;
      base_reached = item_i.start ? (!anch_ff && init_ff[n_cur]) : reached_ff;
      stepv        = '0;
      for (int i = 0; i < rrpm_pkg::MAX_PATTERN_LEN; i++) begin
         live = base[i] && (rrpm_pkg::LEN_W'(i) < n_cur);
         if (live && star_cur[i]) begin
            stepv[i] = 1'b1;
         end else if (live && (pat_ff[i] == item_i.data_byte)) begin
            stepv[i+1] = 1'b1;
         end
      end
      adv_vec     = closure(stepv, m_cur);
      reached_new = base_reached || (!anch_ff && adv_vec[n_cur]);
      hit         = valid_ff && (anch_ff ? adv_vec[n_cur] : reached_new);

      pat_in     = pat_ff;
      len_in     = len_ff;
      valid_in   = valid_ff;
      ovf_in     = ovf_ff;
      grants_in  = grants_ff;
      anch_in    = anch_ff;
      active_in  = active_ff;
      reached_in = reached_ff;
      l_len      = valid_ff ? '0 : len_ff;
      last_pos   = len_ff - rrpm_pkg::LEN_W'(1);
      close_ok   = (len_ff != '0) && !ovf_ff;

      if (en) begin
         case (item_i.func)
            rrpm_pkg::FUNC_CLEAR: begin
               len_in    = '0;
               valid_in  = 1'b0;
               ovf_in    = 1'b0;
               grants_in = 1'b0;
               anch_in   = 1'b0;
            end
            rrpm_pkg::FUNC_APPEND: begin
               if (sel) begin
                  valid_in = 1'b0;
                  anch_in  = 1'b0;
                  ovf_in   = valid_ff ? 1'b0 : ovf_ff;
                  len_in   = l_len;
                  if (l_len >= rrpm_pkg::LEN_W'(rrpm_pkg::MAX_PATTERN_LEN)) begin
                     ovf_in = 1'b1;
                  end else begin
                     for (int i = 0; i < rrpm_pkg::MAX_PATTERN_LEN; i++) begin
                        if (rrpm_pkg::PIDX_W'(i) == l_len[rrpm_pkg::PIDX_W-1:0]) begin
                           pat_in[i] = item_i.data_byte;
                        end
                     end
                     len_in = l_len + rrpm_pkg::LEN_W'(1);
                  end
               end
            end
            rrpm_pkg::FUNC_CLOSE: begin
               if (sel) begin
                  grants_in = item_i.grants_access;
                  valid_in  = close_ok;
                  anch_in   = close_ok && (pat_ff[last_pos[rrpm_pkg::PIDX_W-1:0]] ==
                                           rrpm_pkg::DOLLAR_BYTE);
               end
            end
            rrpm_pkg::FUNC_PATH: begin
               active_in  = adv_vec;
               reached_in = reached_new;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end

      // start vector for the next path, from the table as it will stand
      init_in = closure(rrpm_pkg::POS_N'(1),
                        star_bits(pat_in) &
                        len_mask(len_in - rrpm_pkg::LEN_W'(anch_in)));

      take = item_i.valid && (item_i.func == rrpm_pkg::FUNC_PATH) && item_i.path_end &&
             hit && (!best_i.matched || (n_cur > best_i.len) ||
                     ((n_cur == best_i.len) && grants_ff));

      best_in = best_i;
      if (take) begin
         best_in.matched = 1'b1;
         best_in.allow   = grants_ff;
         best_in.slot    = cell_index;
         best_in.len     = n_cur;
      end

      item_in = advance ? item_i : item_ff;
      if (!advance) begin
         best_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         valid_ff      <= 1'b0;
         ovf_ff        <= 1'b0;
         grants_ff     <= 1'b0;
         anch_ff       <= 1'b0;
         active_ff     <= '0;
         reached_ff    <= 1'b0;
         init_ff       <= rrpm_pkg::POS_N'(1);
         item_ff.valid <= 1'b0;
      end else begin
         len_ff     <= len_in;
         valid_ff   <= valid_in;
         ovf_ff     <= ovf_in;
         grants_ff  <= grants_in;
         anch_ff    <= anch_in;
         active_ff  <= active_in;
         reached_ff <= reached_in;
         init_ff    <= init_in;
         item_ff    <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff  <= pat_in;
      best_ff <= best_in;
   end

   assign item_o = item_ff;
   assign best_o = best_ff;

endmodule

@@ hdl/rrpm_out_stage.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrpm_out_stage
// Response register: holds a verdict until the receiver takes it.
// ---------------------------------------------------------------------------
module rrpm_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rrpm_pkg::best_type best,
   output logic               hold,
   rrpm_rsp_if.source         rsp_if
);

   logic               valid_ff, valid_in;
   rrpm_pkg::best_type best_ff, best_in;

   always_comb begin
      hold     = valid_ff && !rsp_if.ready;
      valid_in = load || hold;
      best_in  = load ? best : best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign rsp_if.valid            = valid_ff;
   assign rsp_if.path_allowed     = best_ff.allow;
   assign rsp_if.any_rule_matched = best_ff.matched;
   assign rsp_if.winning_slot     = rrpm_pkg::slot_field(best_ff.slot);
   assign rsp_if.winning_length   = rrpm_pkg::len_field(best_ff.len);

endmodule

@@ hdl/robots_rule_path_matcher.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// robots_rule_path_matcher
// Allow/disallow rule table with parallel wildcard matching of path bytes.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one transaction per cycle: clear the table, append a
//   pattern byte to a slot, close a slot as allow or disallow, or stream a
//   path byte. The byte flagged path_end yields one verdict on rsp_if.
//   Transactions walk a chain of one cell per rule slot, one cell per cycle
//   while the chain advances; the last cell hands the verdict to the
//   response register. Throughput is one transaction per cycle while
//   req_if.ready is high, set by the single automaton update each cell makes per byte.
//   When rsp_if.ready is low the verdict is held in the response register;
//   the chain keeps moving and req_if.ready drops only while a second
//   verdict has reached the end of the chain.
//   Reset empties the rule table (all slots invalid, lengths zero) and ends
//   any path in progress; pattern bytes themselves are not cleared, and the
//   block accepts transactions in the first cycle after reset.
// ---------------------------------------------------------------------------
module robots_rule_path_matcher (
   input  logic       clock,
   input  logic       reset,
   rrpm_req_if.sink   req_if,
   rrpm_rsp_if.source rsp_if
);

   rrpm_pkg::item_type item_chain [rrpm_pkg::MAX_RULES+1];
   rrpm_pkg::best_type best_chain [rrpm_pkg::MAX_RULES+1];

   logic path_active_ff, path_active_in;
   logic accept, advance, out_hold, result_load;

   always_comb begin
      accept  = req_if.valid && req_if.ready;
      advance = !(rrpm_pkg::item_has_result(item_chain[rrpm_pkg::MAX_RULES]) && out_hold);
      result_load = advance && rrpm_pkg::item_has_result(item_chain[rrpm_pkg::MAX_RULES]);

      item_chain[0].valid         = req_if.valid;
      item_chain[0].func          = rrpm_pkg::func_type'(req_if.func);
      item_chain[0].start         = (item_chain[0].func == rrpm_pkg::FUNC_PATH) &&
                                    !path_active_ff;
      item_chain[0].rule_slot     = req_if.rule_slot;
      item_chain[0].data_byte     = req_if.data_byte;
      item_chain[0].grants_access = req_if.grants_access;
      item_chain[0].path_end      = req_if.path_end;
      best_chain[0]               = rrpm_pkg::BEST_NONE;

      path_active_in = path_active_ff;
      if (accept) begin
         path_active_in = (item_chain[0].func == rrpm_pkg::FUNC_PATH) && !req_if.path_end;
      end
   end

   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         path_active_ff <= 1'b0;
      end else begin
         path_active_ff <= path_active_in;
      end
   end

   for (genvar k = 0; k < rrpm_pkg::MAX_RULES; k++) begin : g_cell
      rrpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (rrpm_pkg::IDX_W'(k)),
         .advance    (advance),
         .item_i     (item_chain[k]),
         .best_i     (best_chain[k]),
         .item_o     (item_chain[k+1]),
         .best_o     (best_chain[k+1])
      );
   end

   rrpm_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (result_load),
      .best   (best_chain[rrpm_pkg::MAX_RULES]),
      .hold   (out_hold),
      .rsp_if (rsp_if)
   );

   a_stall_on_full: assert property (@(posedge clock) disable iff (reset)
      (rrpm_pkg::item_has_result(item_chain[rrpm_pkg::MAX_RULES]) && out_hold)
         |-> !req_if.ready)
      else $error("request taken while a verdict is blocked at the chain end");

   a_enter_chain: assert property (@(posedge clock) disable iff (reset)
      accept |=> item_chain[1].valid)
      else $error("accepted transaction did not enter the first cell");

   a_verdict_loaded: assert property (@(posedge clock) disable iff (reset)
      result_load |=> rsp_if.valid)
      else $error("verdict at chain end not presented");

   a_no_match_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.any_rule_matched)
         |-> (rsp_if.path_allowed && (rsp_if.winning_slot == '0) &&
              (rsp_if.winning_length == '0)))
      else $error("unmatched verdict is not the default allow");

endmodule

@@ bench/robots_rule_path_matcher_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// robots_rule_path_matcher_tb
// Self-checking bench for the allow/disallow path matcher. Rules are loaded
// and paths streamed through the request channel; a scoreboard tracks the
// rule table and the wildcard automata of every slot and predicts each
// verdict, which is compared field by field with the response channel.
// Directed cases come first, then random traffic in phases of sender and
// receiver idling.
// ---------------------------------------------------------------------------
module robots_rule_path_matcher_tb;
   import rrpm_pkg::*;

   typedef struct packed {
      func_type          func;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data;
      logic              grants;
      logic              last;
   } request_type;

   typedef struct packed {
      logic                   path_allowed;
      logic                   any_rule_matched;
      logic [SLOT_W-1:0]      winning_slot;
      logic [LEN_FIELD_W-1:0] winning_length;
   } verdict_type;

   typedef logic [DATA_W-1:0] byte_queue_type[$];

   class verdict_tracker;
      logic [DATA_W-1:0] pat [MAX_RULES][MAX_PATTERN_LEN];
      bit [LEN_W-1:0]    plen [MAX_RULES];
      bit                live [MAX_RULES];
      bit                ovf [MAX_RULES];
      bit                grant [MAX_RULES];
      bit                anch [MAX_RULES];
      bit [POS_N-1:0]    active [MAX_RULES];
      bit                reached [MAX_RULES];
      bit                in_path;
      verdict_type       pending [$];
      int                errors;

      function new();
         for (int r = 0; r < MAX_RULES; r++) begin
            for (int i = 0; i < MAX_PATTERN_LEN; i++) pat[r][i] = '0;
            plen[r] = '0;
            live[r] = 0;
            ovf[r] = 0;
            grant[r] = 0;
            anch[r] = 0;
            active[r] = '0;
            reached[r] = 0;
         end
         in_path = 0;
         errors = 0;
      endfunction

      function int eff_len(int r);
         int n;
         n = plen[r];
         if (anch[r] && n > 0) n--;
         return n;
      endfunction

      function void star_closure(int r, int n);
         for (int i = 0; i < n; i++)
            if (active[r][i] && pat[r][i % MAX_PATTERN_LEN] == STAR_BYTE)
               active[r][i+1] = 1'b1;
      endfunction

      function void start_path();
         int n;
         for (int r = 0; r < MAX_RULES; r++) begin
            n = eff_len(r);
            active[r] = '0;
            active[r][0] = 1'b1;
            star_closure(r, n);
            reached[r] = !anch[r] && active[r][n];
         end
      endfunction

      function void advance(logic [DATA_W-1:0] c);
         bit [POS_N-1:0]    nxt;
         logic [DATA_W-1:0] p;
         int                n;
         for (int r = 0; r < MAX_RULES; r++) begin
            if (!live[r]) continue;
            n = eff_len(r);
            nxt = '0;
            for (int i = 0; i < n; i++) begin
               if (!active[r][i]) continue;
               p = pat[r][i % MAX_PATTERN_LEN];
               if (p == STAR_BYTE) nxt[i] = 1'b1;
               else if (p == c) nxt[i+1] = 1'b1;
            end
            active[r] = nxt;
            star_closure(r, n);
            if (!anch[r] && active[r][n]) reached[r] = 1'b1;
         end
      endfunction

      function verdict_type decide();
         verdict_type v;
         bit          matched;
         bit          allow;
         bit          hit;
         int          best_len;
         int          best_slot;
         int          n;
         matched = 0;
         allow = 1;
         best_len = 0;
         best_slot = 0;
         for (int r = 0; r < MAX_RULES; r++) begin
            if (!live[r]) continue;
            n = eff_len(r);
            hit = anch[r] ? active[r][n] : reached[r];
            if (!hit) continue;
            if (!matched || n > best_len || (n == best_len && grant[r])) begin
               matched = 1;
               best_len = n;
               best_slot = r;
               allow = grant[r];
            end
         end
         v.path_allowed = matched ? allow : 1'b1;
         v.any_rule_matched = matched;
         v.winning_slot = SLOT_W'(best_slot);
         v.winning_length = LEN_FIELD_W'(best_len);
         return v;
      endfunction

      function void note_request(request_type rq);
         int s;
         int n;
         s = rq.slot;
         case (rq.func)
            FUNC_CLEAR: begin
               for (int r = 0; r < MAX_RULES; r++) begin
                  plen[r] = '0;
                  live[r] = 0;
                  ovf[r] = 0;
                  anch[r] = 0;
                  grant[r] = 0;
               end
               in_path = 0;
            end
            FUNC_APPEND: begin
               in_path = 0;
               if (s >= MAX_RULES) return;
               if (live[s]) begin
                  live[s] = 0;
                  anch[s] = 0;
                  plen[s] = '0;
                  ovf[s] = 0;
               end
               if (plen[s] >= MAX_PATTERN_LEN) begin
                  ovf[s] = 1;
               end else begin
                  pat[s][plen[s]] = rq.data;
                  plen[s] = plen[s] + 1'b1;
               end
            end
            FUNC_CLOSE: begin
               in_path = 0;
               if (s >= MAX_RULES) return;
               n = plen[s];
               grant[s] = rq.grants;
               live[s] = n > 0 && !ovf[s];
               anch[s] = 0;
               if (live[s]) anch[s] = pat[s][(n-1) % MAX_PATTERN_LEN] == DOLLAR_BYTE;
            end
            default: begin
               if (!in_path) start_path();
               advance(rq.data);
               in_path = !rq.last;
               if (rq.last) pending = {pending, decide()};
            end
         endcase
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type exp;
         if (pending.size() == 0) begin
            $error("unexpected verdict: allowed %0d matched %0d slot %0d length %0d",
                   got.path_allowed, got.any_rule_matched, got.winning_slot,
                   got.winning_length);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.path_allowed !== exp.path_allowed) begin
            $error("path_allowed: expected %0d, actual %0d", exp.path_allowed,
                   got.path_allowed);
            errors++;
         end
         if (got.any_rule_matched !== exp.any_rule_matched) begin
            $error("any_rule_matched: expected %0d, actual %0d", exp.any_rule_matched,
                   got.any_rule_matched);
            errors++;
         end
         if (got.winning_slot !== exp.winning_slot) begin
            $error("winning_slot: expected %0d, actual %0d", exp.winning_slot,
                   got.winning_slot);
            errors++;
         end
         if (got.winning_length !== exp.winning_length) begin
            $error("winning_length: expected %0d, actual %0d", exp.winning_length,
                   got.winning_length);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   rrpm_req_if req_if ();
   rrpm_rsp_if rsp_if ();

   robots_rule_path_matcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   verdict_tracker tracker;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             items_sent = 0;

   always #2 clock = ~clock;

   initial begin
      #1ms;
      $display("robots_rule_path_matcher_tb: FAIL");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         tracker.check_verdict(verdict_type'{rsp_if.path_allowed, rsp_if.any_rule_matched,
                                             rsp_if.winning_slot, rsp_if.winning_length});
   end

   task automatic send_request(input request_type rq);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.func          <= rq.func;
      req_if.rule_slot     <= rq.slot;
      req_if.data_byte     <= rq.data;
      req_if.grants_access <= rq.grants;
      req_if.path_end      <= rq.last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_request(rq);
      items_sent++;
   endtask

   task automatic put(input func_type f, input int slot, input int data, input bit grants,
                      input bit last);
      request_type rq;
      rq.func   = f;
      rq.slot   = SLOT_W'(slot);
      rq.data   = DATA_W'(data);
      rq.grants = grants;
      rq.last   = last;
      send_request(rq);
   endtask

   task automatic load_rule(input int slot, input byte_queue_type bytes, input bit grants);
      foreach (bytes[i]) put(FUNC_APPEND, slot, bytes[i], 1'($urandom), 1'($urandom));
      put(FUNC_CLOSE, slot, $urandom, grants, 1'($urandom));
   endtask

   task automatic send_path(input byte_queue_type bytes, input bit finish);
      foreach (bytes[i])
         put(FUNC_PATH, $urandom, bytes[i], 1'($urandom), finish && i == bytes.size() - 1);
   endtask

   function automatic byte_queue_type text(input string s);
      byte_queue_type q;
      for (int i = 0; i < s.len(); i++) q = {q, s[i]};
      return q;
   endfunction

   function automatic logic [DATA_W-1:0] pattern_byte(input bit star_heavy);
      int r;
      r = $urandom_range(99);
      if (star_heavy) return (r < 60) ? STAR_BYTE : (r < 75) ? "a" : (r < 90) ? "b" : "/";
      if (r < 30) return "/";
      if (r < 50) return "a";
      if (r < 70) return "b";
      if (r < 90) return STAR_BYTE;
      if (r < 95) return DOLLAR_BYTE;
      return DATA_W'($urandom);
   endfunction

   function automatic logic [DATA_W-1:0] path_byte();
      int r;
      r = $urandom_range(99);
      if (r < 30) return "/";
      if (r < 60) return "a";
      if (r < 88) return "b";
      if (r < 92) return STAR_BYTE;
      if (r < 95) return DOLLAR_BYTE;
      return DATA_W'($urandom);
   endfunction

   task automatic random_rule();
      byte_queue_type q;
      int             len;
      bit             long_one;
      long_one = $urandom_range(99) < 15;
      len = long_one ? $urandom_range(34, 30) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++)
         q = {q, ((i == 0 && $urandom_range(99) < 70) ? 8'h2F : pattern_byte(long_one))};
      if ($urandom_range(99) < 25) q = {q, DOLLAR_BYTE};
      if ($urandom_range(99) < 90) begin
         load_rule($urandom_range(MAX_RULES - 1), q, 1'($urandom));
      end else begin
         foreach (q[i]) put(FUNC_APPEND, $urandom, q[i], 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic random_path();
      byte_queue_type q;
      int             len;
      len = ($urandom_range(99) < 90) ? $urandom_range(8, 1) : $urandom_range(40, 9);
      for (int i = 0; i < len; i++)
         q = {q, ((i == 0 && $urandom_range(99) < 80) ? 8'h2F : path_byte())};
      send_path(q, $urandom_range(99) >= 8);
   endtask

   task automatic random_phase(input int count, input int idle, input int stall);
      int first;
      int r;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      first = items_sent;
      while (items_sent - first < count) begin
         r = $urandom_range(99);
         if (r < 3) put(FUNC_CLEAR, $urandom, $urandom, 1'($urandom), 1'($urandom));
         else if (r < 33) random_rule();
         else if (r < 36) put(FUNC_CLOSE, $urandom, $urandom, 1'($urandom), 1'($urandom));
         else if (r < 42) put(func_type'($urandom_range(3)), $urandom, $urandom,
                              1'($urandom), 1'($urandom));
         else random_path();
      end
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      req_if.valid         = 1'b0;
      req_if.func          = FUNC_CLEAR;
      req_if.rule_slot     = '0;
      req_if.data_byte     = '0;
      req_if.grants_access = 1'b0;
      req_if.path_end      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: allowed, nothing matched
      send_path(text("/"), 1'b1);
      load_rule(0, text("/p$"), 1'b0);
      load_rule(1, text("/*"), 1'b1);
      // equal length: allow beats disallow
      send_path(text("/p"), 1'b1);
      send_path(text("/pq"), 1'b1);
      // lone dollar and empty close stay unmatched
      load_rule(2, text("$"), 1'b0);
      put(FUNC_CLOSE, 3, 8'h00, 1'b1, 1'b0);
      put(FUNC_PATH, 7, 8'hFF, 1'b1, 1'b1);
      // clear in the middle of a path
      put(FUNC_PATH, 0, "/", 1'b0, 1'b0);
      put(FUNC_CLEAR, 7, 8'hFF, 1'b1, 1'b1);
      put(FUNC_PATH, 0, "/", 1'b0, 1'b1);
      // reopen a closed slot with a new pattern
      load_rule(5, text("/a"), 1'b0);
      load_rule(5, text("*"), 1'b1);
      send_path(text("/b"), 1'b1);

      random_phase(463, 0, 0);
      random_phase(463, 72, 0);
      random_phase(462, 0, 72);
      random_phase(462, 25, 25);

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (MAX_RULES + 4) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("robots_rule_path_matcher_tb: PASS");
      end else begin
         $display("robots_rule_path_matcher_tb: FAIL");
      end
      $finish;
   end

endmodule
